FILE: design/puic_pkg.sv
package puic_pkg;

  // what the input word carries, sent on tuser
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVENT = 1'b1
  } kind_e;

  // register numbers; 0 and 7 are unused
  typedef enum logic [2:0] {
    REG_NONE_LO = 3'd0,
    REG_MODE    = 3'd1,
    REG_DISABLE = 3'd2,
    REG_ENABLE  = 3'd3,
    REG_LOW     = 3'd4,
    REG_HIGH    = 3'd5,
    REG_KEY     = 3'd6,
    REG_NONE_HI = 3'd7
  } reg_e;

  // counting source, low two bits of the mode byte
  typedef enum logic [1:0] {
    SRC_PPU    = 2'd0,
    SRC_RENDER = 2'd1,
    SRC_OFF_A  = 2'd2,
    SRC_OFF_B  = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_OUT
  } state_e;

  localparam int unsigned TickW       = 8;
  localparam int unsigned CycW        = 9;
  localparam int unsigned DownBit     = 7;
  localparam int unsigned UpBit       = 6;
  localparam int unsigned ShortBit    = 2;
  localparam logic [7:0]  MaskShort   = 8'h07;
  localparam logic [7:0]  MaskLong    = 8'hFF;
  localparam logic [TickW-1:0] RenderTicks = 8'd8;
  // floor(x/3) == (x*171)>>9 for every 9-bit x
  localparam logic [7:0]  Div3Recip   = 8'd171;
  localparam int unsigned Div3Shift   = 9;

  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic tick;    // apply one counter tick
    logic load;    // copy the finished result into the output register
  } ctrl_cmd_t;

endpackage

FILE: design/puic_ctrl.sv
module puic_ctrl
  import puic_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [TickW-1:0] ticks_i,
  output ctrl_cmd_t        cmd_o
);

  state_e           state_q, state_d;
  logic [TickW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // output register empty or emptied at this edge
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.tick   = 1'b0;
    cmd_o.load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = ticks_i;
          if (ticks_i != '0) begin
            state_d = ST_TICK;
          end else if (out_free) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_TICK: begin
        cmd_o.tick = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == TickW'(1)) begin
          if (out_free) begin
            cmd_o.load = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // finished result waits for the output register
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load || (out_valid_q && !out_ready_i);
  end

endmodule

FILE: design/puic_datapath.sv
module puic_datapath
  import puic_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic             kind_i,
  input  logic [2:0]       reg_index_i,
  input  logic [7:0]       write_data_i,
  input  logic [CycW-1:0]  ppu_cycles_i,
  input  logic             render_both_on_i,
  output logic [TickW-1:0] ticks_o,
  output logic             irq_raise_o,
  output logic [7:0]       count_low_o,
  output logic [7:0]       count_high_o
);

  logic       enable_q, enable_d;
  logic [7:0] mode_q, mode_d;
  logic [7:0] key_q, key_d;
  logic [7:0] presc_q, presc_d;
  logic [7:0] high_q, high_d;
  logic       irq_q, irq_d;
  logic       out_irq_q;
  logic [7:0] out_low_q;
  logic [7:0] out_high_q;

  logic [CycW+7:0] div_prod;
  logic [7:0]      mask;
  logic [7:0]      p_dn, h_dn, p_up, h_up;
  logic            wrap_dn, wrap_up;

  // tick count for an event, zero for writes and when stopped
  assign div_prod = (CycW+8)'(ppu_cycles_i) * (CycW+8)'(Div3Recip);

  always_comb begin
    ticks_o = '0;
    if (kind_e'(kind_i) == KIND_EVENT && enable_q) begin
      case (src_e'(mode_q[1:0]))
        SRC_PPU:    ticks_o = div_prod[Div3Shift +: TickW];
        SRC_RENDER: ticks_o = render_both_on_i ? RenderTicks : '0;
        default:    ticks_o = '0;
      endcase
    end
  end

  // one tick: down step first, then up step
  always_comb begin
    mask    = mode_q[ShortBit] ? MaskShort : MaskLong;
    p_dn    = presc_q;
    h_dn    = high_q;
    wrap_dn = 1'b0;
    if (mode_q[DownBit]) begin
      p_dn = presc_q - 1'b1;
      if ((p_dn & mask) == mask) begin
        h_dn    = high_q - 1'b1;
        wrap_dn = (high_q == 8'h00);
      end
    end
    p_up    = p_dn;
    h_up    = h_dn;
    wrap_up = 1'b0;
    if (mode_q[UpBit]) begin
      p_up = p_dn + 1'b1;
      if ((p_up & mask) == 8'h00) begin
        h_up    = h_dn + 1'b1;
        wrap_up = (h_dn == 8'hFF);
      end
    end
  end

  always_comb begin
    enable_d = enable_q;
    mode_d   = mode_q;
    key_d    = key_q;
    presc_d  = presc_q;
    high_d   = high_q;
    irq_d    = irq_q;
    if (cmd_i.accept) begin
      irq_d = 1'b0;
      if (kind_e'(kind_i) == KIND_WRITE) begin
        case (reg_e'(reg_index_i))
          REG_MODE:    mode_d   = write_data_i;
          REG_DISABLE: enable_d = 1'b0;
          REG_ENABLE:  enable_d = 1'b1;
          REG_LOW:     presc_d  = write_data_i ^ key_q;
          REG_HIGH:    high_d   = write_data_i ^ key_q;
          REG_KEY:     key_d    = write_data_i;
          default:     ;
        endcase
      end
    end else if (cmd_i.tick) begin
      presc_d = p_up;
      high_d  = h_up;
      irq_d   = irq_q | wrap_dn | wrap_up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      mode_q   <= '0;
      key_q    <= '0;
      presc_q  <= '0;
      high_q   <= '0;
      irq_q    <= 1'b0;
    end else begin
      enable_q <= enable_d;
      mode_q   <= mode_d;
      key_q    <= key_d;
      presc_q  <= presc_d;
      high_q   <= high_d;
      irq_q    <= irq_d;
    end
  end

  // result word, taken from the values the item leaves behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_irq_q  <= 1'b0;
      out_low_q  <= '0;
      out_high_q <= '0;
    end else if (cmd_i.load) begin
      out_irq_q  <= irq_d;
      out_low_q  <= presc_d;
      out_high_q <= high_d;
    end
  end

  assign irq_raise_o  = out_irq_q;
  assign count_low_o  = out_low_q;
  assign count_high_o = out_high_q;

endmodule

FILE: design/prescaled_updown_irq_counter.sv
// timing: a result is loaded into the output register once its word's ticks are done
//   (0 to 170 ticks: ppu_cycles/3 or 8), as the word is taken if it runs none, and only
//   while that register is free; one tick runs per cycle, and no new word is taken until
//   those ticks are done; the output register lets the next word in while a result waits,
//   and a result finished before the last one is taken holds the counter in a wait state
// reset: rst_ni asynchronous active low; mode, key, enable and counts clear
module prescaled_updown_irq_counter
  import puic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_index[2:0], write_data[10:3], ppu_cycles[19:11], render_both_on[20], zero fill
  input  logic [23:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // irq_raise[0], count_low[8:1], count_high[16:9], zero fill
  output logic [23:0] m_axis_tdata
);

  ctrl_cmd_t        cmd;
  logic [TickW-1:0] ticks;
  logic             irq_raise;
  logic [7:0]       count_low;
  logic [7:0]       count_high;

  // sequencer: takes the word, then steps the tick count down one per cycle
  puic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ticks_i     (ticks),
    .cmd_o       (cmd)
  );

  // registers, tick count decode and the down/up step logic
  puic_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (s_axis_tuser),
    .reg_index_i      (s_axis_tdata[2:0]),
    .write_data_i     (s_axis_tdata[10:3]),
    .ppu_cycles_i     (s_axis_tdata[19:11]),
    .render_both_on_i (s_axis_tdata[20]),
    .ticks_o          (ticks),
    .irq_raise_o      (irq_raise),
    .count_low_o      (count_low),
    .count_high_o     (count_high)
  );

  // result registers hold steady while the result word waits
  assign m_axis_tdata = {7'd0, count_high, count_low, irq_raise};

endmodule

FILE: tb/sv/prescaled_updown_irq_counter_tb.sv
`timescale 1ns / 1ps

module prescaled_updown_irq_counter_tb;
  import puic_pkg::*;

  // one input word as the bench sees it, before packing onto tdata and tuser
  typedef struct packed {
    kind_e      kind;
    reg_e       reg_sel;
    logic [7:0] data;
    logic [8:0] cycles;
    logic       render;
  } line_word_t;

  // one result word: interrupt flag and both counter bytes
  typedef struct packed {
    logic       irq;
    logic [7:0] low;
    logic [7:0] high;
  } counts_t;

  // directed row; when typed is set the result is written out by hand
  typedef struct packed {
    line_word_t w;
    logic       typed;
    counts_t    want;
  } plan_row_t;

  localparam int unsigned RandWords = 1550;
  localparam int unsigned QuietTail = 200;
  localparam int unsigned DrainWait = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // predicted block state
  logic        cnt_on;
  logic [7:0]  mode_q;
  logic [7:0]  key_q;
  logic [7:0]  presc_q;
  logic [7:0]  high_q;

  counts_t     counts_due[$];
  int unsigned errors;
  int unsigned idle_pct;      // chance of a stall burst on either side, per cent

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  prescaled_updown_irq_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // directed words: disabled event, unused registers, keyed loads, up count
  // through a wrap, the longest cycle count, short prescaler counting down,
  // both directions in render mode with and without full rendering, the two
  // stopped sources, and an event after disable. register fields on events
  // and event fields on writes carry junk on purpose
  localparam plan_row_t Plan [25] = '{
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd341, 1'b1}, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{'{KIND_WRITE, REG_NONE_LO, 8'hFF, 9'h1FF, 1'b1}, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{'{KIND_WRITE, REG_NONE_HI, 8'hFF, 9'h1FF, 1'b1}, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{'{KIND_WRITE, REG_KEY,     8'hA5, 9'd0,   1'b0}, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{'{KIND_WRITE, REG_LOW,     8'hA5, 9'd12,  1'b0}, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{'{KIND_WRITE, REG_HIGH,    8'h5A, 9'd0,   1'b1}, 1'b1, '{1'b0, 8'h00, 8'hFF}},
    '{'{KIND_WRITE, REG_KEY,     8'h00, 9'd0,   1'b0}, 1'b1, '{1'b0, 8'h00, 8'hFF}},
    '{'{KIND_WRITE, REG_MODE,    8'h40, 9'd0,   1'b0}, 1'b1, '{1'b0, 8'h00, 8'hFF}},
    '{'{KIND_WRITE, REG_ENABLE,  8'h00, 9'h155, 1'b1}, 1'b1, '{1'b0, 8'h00, 8'hFF}},
    '{'{KIND_EVENT, REG_KEY,     8'h77, 9'd2,   1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_MODE,    8'hFF, 9'd3,   1'b0}, 1'b0, '0},
    '{'{KIND_WRITE, REG_LOW,     8'hFF, 9'd0,   1'b0}, 1'b1, '{1'b0, 8'hFF, 8'hFF}},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd5,   1'b1}, 1'b0, '0},
    '{'{KIND_EVENT, REG_DISABLE, 8'h00, 9'h1FF, 1'b1}, 1'b0, '0},
    '{'{KIND_WRITE, REG_MODE,    8'h84, 9'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd341, 1'b0}, 1'b0, '0},
    '{'{KIND_WRITE, REG_MODE,    8'hC1, 9'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd341, 1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd0,   1'b1}, 1'b0, '0},
    '{'{KIND_WRITE, REG_MODE,    8'hC2, 9'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd341, 1'b1}, 1'b0, '0},
    '{'{KIND_WRITE, REG_MODE,    8'h47, 9'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd341, 1'b1}, 1'b0, '0},
    '{'{KIND_WRITE, REG_DISABLE, 8'h00, 9'd0,   1'b0}, 1'b0, '0},
    '{'{KIND_EVENT, REG_NONE_LO, 8'h00, 9'd300, 1'b1}, 1'b0, '0}
  };

  // apply one accepted word to the predicted state and return its result
  function automatic counts_t predict_counts(line_word_t w);
    logic [7:0] mask;
    int         ticks;
    counts_t    r;
    ticks = 0;
    r.irq = 1'b0;
    if (w.kind == KIND_WRITE) begin
      case (w.reg_sel)
        REG_MODE:    mode_q = w.data;
        REG_DISABLE: cnt_on = 1'b0;
        REG_ENABLE:  cnt_on = 1'b1;
        REG_LOW:     presc_q = w.data ^ key_q;
        REG_HIGH:    high_q = w.data ^ key_q;
        REG_KEY:     key_q = w.data;
        default:     ;
      endcase
    end else if (cnt_on) begin
      case (src_e'(mode_q[1:0]))
        SRC_PPU:    ticks = w.cycles / 3;
        SRC_RENDER: ticks = w.render ? int'(RenderTicks) : 0;
        default:    ticks = 0;
      endcase
      mask = mode_q[ShortBit] ? MaskShort : MaskLong;
      for (int i = 0; i < ticks; i++) begin
        // down step first, then up; either may wrap the high byte
        if (mode_q[DownBit]) begin
          presc_q = presc_q - 8'd1;
          if ((presc_q & mask) == mask) begin
            high_q = high_q - 8'd1;
            if (high_q == 8'hFF) r.irq = 1'b1;
          end
        end
        if (mode_q[UpBit]) begin
          presc_q = presc_q + 8'd1;
          if ((presc_q & mask) == 8'h00) begin
            high_q = high_q + 8'd1;
            if (high_q == 8'h00) r.irq = 1'b1;
          end
        end
      end
    end
    r.low  = presc_q;
    r.high = high_q;
    return r;
  endfunction

  // random word: about half events, the rest register writes weighted toward
  // enable and loads so that counting runs most of the time
  function automatic line_word_t rand_word();
    line_word_t  w;
    int unsigned pick;
    w.reg_sel = reg_e'($urandom_range(0, 7));
    w.data    = 8'($urandom_range(0, 255));
    w.cycles  = 9'($urandom_range(0, 511));
    w.render  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 50) begin
      w.kind = KIND_EVENT;
      pick = $urandom_range(0, 99);
      // mostly short lines keep words moving; full lines and beyond now and then
      if (pick < 70) w.cycles = 9'($urandom_range(0, 60));
      else if (pick < 95) w.cycles = 9'($urandom_range(0, 341));
      else w.cycles = 9'($urandom_range(342, 511));
      if ($urandom_range(0, 3) != 0) w.render = 1'b1;
    end else begin
      w.kind = KIND_WRITE;
      pick = $urandom_range(0, 19);
      if (pick < 4 || pick == 19) w.reg_sel = REG_MODE;
      else if (pick == 4) w.reg_sel = REG_DISABLE;
      else if (pick < 9) w.reg_sel = REG_ENABLE;
      else if (pick < 12) w.reg_sel = REG_LOW;
      else if (pick < 15) w.reg_sel = REG_HIGH;
      else if (pick < 17) w.reg_sel = REG_KEY;
      else if (pick == 17) w.reg_sel = REG_NONE_LO;
      else w.reg_sel = REG_NONE_HI;
      // keep the source on a counting one most of the time
      if (w.reg_sel == REG_MODE && $urandom_range(0, 4) != 0)
        w.data[1:0] = $urandom_range(0, 1) ? SRC_RENDER : SRC_PPU;
      // high loads near the wrap points, undoing the key
      if (w.reg_sel == REG_HIGH && $urandom_range(0, 1))
        w.data = key_q ^ ($urandom_range(0, 1) ? 8'hFF - 8'($urandom_range(0, 3))
                                                : 8'($urandom_range(0, 3)));
    end
    return w;
  endfunction

  // offer one word, hold it until taken, then book its expected result
  task automatic send_word(line_word_t w, logic typed, counts_t want);
    counts_t calc;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, w.render, w.cycles, w.data, w.reg_sel};
    s_axis_tuser  <= w.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    calc = predict_counts(w);
    counts_due.push_back(typed ? want : calc);
  endtask

  // hold the input side until every booked result is out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (counts_due.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each taken word, then pick tready for the next cycle
  initial begin
    counts_t     got;
    counts_t     want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.irq  = m_axis_tdata[0];
        got.low  = m_axis_tdata[8:1];
        got.high = m_axis_tdata[16:9];
        if (counts_due.size() == 0) begin
          $error("result word with nothing expected: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = counts_due.pop_front();
          if (got.irq !== want.irq) begin
            $error("irq_raise: expected %0d, got %0d", want.irq, got.irq);
            errors++;
          end
          if (got.low !== want.low) begin
            $error("count_low: expected %h, got %h", want.low, got.low);
            errors++;
          end
          if (got.high !== want.high) begin
            $error("count_high: expected %h, got %h", want.high, got.high);
            errors++;
          end
        end
      end
      if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        stall_left = $urandom_range(1, 7);
      m_axis_tready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // stimulus and end of run
  initial begin
    errors   = 0;
    idle_pct = 20;
    cnt_on   = 1'b0;
    mode_q   = '0;
    key_q    = '0;
    presc_q  = '0;
    high_q   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Plan[i]) send_word(Plan[i].w, Plan[i].typed, Plan[i].want);

    for (int unsigned n = 0; n < RandWords; n++) begin
      // sender waits out the whole pipe now and then
      if (n % 400 == 0) drain_results();
      // stall rate changes per stretch; the tail runs with none
      if (n >= RandWords - QuietTail) idle_pct = 0;
      else if (n % 250 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      send_word(rand_word(), 1'b0, '0);
    end

    drain_results();
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0 && counts_due.size() == 0) begin
      $display("PASS prescaled_updown_irq_counter");
    end else begin
      $display("FAIL prescaled_updown_irq_counter");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("FAIL prescaled_updown_irq_counter");
    $finish;
  end

endmodule

FILE: sim.f
design/puic_pkg.sv
design/puic_ctrl.sv
design/puic_datapath.sv
design/prescaled_updown_irq_counter.sv
tb/sv/prescaled_updown_irq_counter_tb.sv
